>>> rtl/strand_fragment_counter_defines.svh
// Assertion macros shared by the strand fragment counter RTL.
`ifndef STRAND_FRAGMENT_COUNTER_DEFINES_SVH
`define STRAND_FRAGMENT_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent assertion on an explicit clock and active-low reset.
`define SFC_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SFC_ASSERT(label, prop, msg) \
  `SFC_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`else

`define SFC_ASSERT_AT(label, clk, rstn, prop, msg)
`define SFC_ASSERT(label, prop, msg)

`endif

`endif

>>> rtl/sfc_pkg.sv
// Shared types and constants of the strand fragment counter.
package sfc_pkg;

  localparam int METRICS = 21;
  localparam int MIDX_W  = $clog2(METRICS);

  // Item kinds
  localparam logic [1:0] KIND_REC = 2'd0;
  localparam logic [1:0] KIND_TGT = 2'd1;
  localparam logic [1:0] KIND_MET = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NEG_TGT = 3'd1;
  localparam logic [2:0] ST_UNUSUAL = 3'd2;
  localparam logic [2:0] ST_ORDER   = 3'd3;
  localparam logic [2:0] ST_UNLIKELY = 3'd4;

  // Register index decoded from paddr
  localparam logic REG_MODE = 1'b0;

  // SAM flag bit positions
  localparam int FL_PROPER = 1;
  localparam int FL_UNMAP  = 2;
  localparam int FL_MUNMAP = 3;
  localparam int FL_REV    = 4;
  localparam int FL_MREV   = 5;
  localparam int FL_R1     = 6;
  localparam int FL_R2     = 7;

  // Global metric counter numbers
  localparam int M_S_R1        = 0;
  localparam int M_S_R2        = 1;
  localparam int M_S_R1_IMP    = 2;
  localparam int M_S_R2_IMP    = 3;
  localparam int M_S_R1_MUN    = 4;
  localparam int M_S_R2_MUN    = 5;
  localparam int M_A_R1        = 6;
  localparam int M_A_R2        = 7;
  localparam int M_A_R1_IMP    = 8;
  localparam int M_A_R2_IMP    = 9;
  localparam int M_A_R1_MUN    = 10;
  localparam int M_A_R2_MUN    = 11;
  localparam int M_BOTH_FWD    = 12;
  localparam int M_BOTH_REV    = 13;
  localparam int M_TOTAL       = 14;
  localparam int M_UNMAPPED    = 15;
  localparam int M_SENSE_FRAG  = 16;
  localparam int M_ANTI_FRAG   = 17;
  localparam int M_UNEQUAL     = 18;
  localparam int M_SINGLE_S    = 19;
  localparam int M_SINGLE_A    = 20;

  // Update plan for one record, produced by the classifier
  typedef struct packed {
    logic [2:0]               status;
    logic                     a_valid;
    logic [9:0]               a_addr;
    logic                     sense;
    logic                     a_two;
    logic                     b_valid;
    logic [9:0]               b_addr;
    logic [METRICS-1:0][1:0]  madd;
  } plan_t;

endpackage

>>> rtl/strand_fragment_counter.sv
// Top level of the strand-aware read and fragment counter.
//
// Usage:
//   Items enter on start while busy is low; kind_i picks a record update,
//   a per-target counter read-out or a global metric read-out. Each item
//   gives exactly one result, shown for one cycle with done_o high. The
//   receiver cannot stall: a result must be taken in its strobe cycle.
//   Path from the accepting edge to the result strobe:
//     metric read-outs, errors, records touching no target - registered directly
//     target read-outs, records touching one target - via state S_A
//     pairs touching two different targets - via S_A, then S_B
//   The path is set by the table RAM: one read-modify-write per target,
//   with a registered read. A new item may be accepted in the strobe
//   cycle of the previous one.
//   The APB port holds the mode register (0 pairs, 1 single reads); write
//   it only while the block is idle.
//   After reset, busy stays high while a clearing pass zeroes the
//   per-target table, one entry a cycle.
module strand_fragment_counter
  import sfc_pkg::*;
#(
  parameter int TARGETS     = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        first_flags_i,
  input  logic signed [10:0] first_target_i,
  input  logic [15:0]        second_flags_i,
  input  logic signed [10:0] second_target_i,
  input  logic [9:0]         read_index_i,
  // result
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [31:0]        sense_reads_o,
  output logic [31:0]        antisense_reads_o,
  output logic [31:0]        sense_fragments_o,
  output logic [31:0]        antisense_fragments_o,
  output logic [31:0]        metric_value_o
);

  `include "strand_fragment_counter_defines.svh"

  localparam int AW = $clog2(TARGETS);
  localparam int CW = COUNT_WIDTH;
  localparam int RW = 4 * CW;

  // Sequencer states
  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_A    = 2'd2;
  localparam logic [1:0] S_B    = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic          mode_q;
  logic          done_q;
  logic          b_valid_q;
  logic          tgt_q, sense_q, a_two_q;
  logic [AW-1:0] a_addr_q, b_addr_q;

  logic [2:0]    status_q;
  logic [31:0]   s_reads_q, a_reads_q, s_frags_q, a_frags_q, metric_q;

  plan_t         plan;
  logic          acc, cfg_wr;
  logic          kind_rec, kind_tgt, kind_met;
  logic          idx_ok, item_ram, finish;
  logic [AW-1:0] item_addr;
  logic [31:0]   met_val;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata, upd_word;
  logic [CW-1:0] cur_reads, cur_frags, new_reads, new_frags;
  logic [CW+1:0] sum_reads, sum_frags;
  logic [1:0]    reads_add;

  // --------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------
  assign busy   = (state_q != S_IDLE);
  assign acc    = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

  assign kind_rec = (kind_i == KIND_REC);
  assign kind_tgt = (kind_i == KIND_TGT);
  assign kind_met = (kind_i == KIND_MET);
  assign idx_ok   = ({22'd0, read_index_i} < 32'(TARGETS));

  // --------------------------------------------------------------------
  // Record classification and global metrics
  // --------------------------------------------------------------------
  sfc_decode #(
    .TARGETS(TARGETS)
  ) u_decode (
    .mode_i          (mode_q),
    .first_flags_i   (first_flags_i),
    .first_target_i  (first_target_i),
    .second_flags_i  (second_flags_i),
    .second_target_i (second_target_i),
    .plan_o          (plan)
  );

  // Metrics advance at the accepting edge; the increments are all-zero on error.
  sfc_metrics #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_metrics (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (acc && kind_rec),
    .add_i   (plan.madd),
    .idx_i   (read_index_i),
    .value_o (met_val)
  );

  // --------------------------------------------------------------------
  // Target table: one word per target holding all four counters,
  // {antisense frags, sense frags, antisense reads, sense reads}.
  // --------------------------------------------------------------------
  assign item_ram  = (kind_rec && plan.a_valid) || (kind_tgt && idx_ok);
  assign item_addr = kind_tgt ? AW'({22'd0, read_index_i})
                              : AW'({22'd0, plan.a_addr});

  // Read the first entry with the accepting edge, the second entry while
  // the first is written back. The two entries of a pair always differ,
  // and busy holds off the next item until the last write has landed, so
  // no read can overtake a pending write.
  assign ram_re    = (acc && item_ram) || ((state_q == S_A) && b_valid_q);
  assign ram_raddr = (state_q == S_A) ? b_addr_q : item_addr;

  assign ram_we    = (state_q == S_CLR) || ((state_q == S_A) && !tgt_q) ||
                     (state_q == S_B);
  assign ram_waddr = (state_q == S_CLR) ? clr_q :
                     (state_q == S_A)   ? a_addr_q : b_addr_q;
  assign ram_wdata = (state_q == S_CLR) ? '0 : upd_word;

  sfc_ram #(
    .WIDTH(RW),
    .DEPTH(TARGETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Saturating modify: one fragment, and one or two reads on the strand.
  assign reads_add = ((state_q == S_A) && a_two_q) ? 2'd2 : 2'd1;
  assign cur_reads = sense_q ? ram_rdata[CW-1:0]    : ram_rdata[2*CW-1:CW];
  assign cur_frags = sense_q ? ram_rdata[3*CW-1:2*CW] : ram_rdata[4*CW-1:3*CW];
  assign sum_reads = {2'b00, cur_reads} + {{CW{1'b0}}, reads_add};
  assign sum_frags = {2'b00, cur_frags} + {{CW{1'b0}}, 2'd1};
  assign new_reads = (|sum_reads[CW+1:CW]) ? {CW{1'b1}} : sum_reads[CW-1:0];
  assign new_frags = (|sum_frags[CW+1:CW]) ? {CW{1'b1}} : sum_frags[CW-1:0];

  always_comb begin
    upd_word = ram_rdata;
    if (sense_q) begin
      upd_word[CW-1:0]      = new_reads;
      upd_word[3*CW-1:2*CW] = new_frags;
    end else begin
      upd_word[2*CW-1:CW]   = new_reads;
      upd_word[4*CW-1:3*CW] = new_frags;
    end
  end

  // --------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (clr_q == AW'(TARGETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc && item_ram) begin
          state_d = S_A;
        end
      end
      S_A: begin
        state_d = b_valid_q ? S_B : S_IDLE;
      end
      S_B: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign finish = (acc && !item_ram) || ((state_q == S_A) && !b_valid_q) ||
                  (state_q == S_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      mode_q    <= 1'b0;
      done_q    <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_wr && (paddr[2] == REG_MODE)) begin
        mode_q <= pwdata[0];
      end
      if (acc) begin
        b_valid_q <= kind_rec && plan.b_valid;
      end
    end
  end

  // Item context and result registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tgt_q     <= kind_tgt;
      sense_q   <= plan.sense;
      a_two_q   <= plan.a_two;
      a_addr_q  <= item_addr;
      b_addr_q  <= AW'({22'd0, plan.b_addr});
      status_q  <= kind_rec ? plan.status :
                   (kind_tgt && !idx_ok) ? ST_NEG_TGT : ST_OK;
      s_reads_q <= '0;
      a_reads_q <= '0;
      s_frags_q <= '0;
      a_frags_q <= '0;
      metric_q  <= kind_met ? met_val : 32'd0;
    end else if ((state_q == S_A) && tgt_q) begin
      // read-out: low 32 bits of each counter
      s_reads_q <= 32'(64'(ram_rdata[CW-1:0]));
      a_reads_q <= 32'(64'(ram_rdata[2*CW-1:CW]));
      s_frags_q <= 32'(64'(ram_rdata[3*CW-1:2*CW]));
      a_frags_q <= 32'(64'(ram_rdata[4*CW-1:3*CW]));
    end
  end

  assign done_o                = done_q;
  assign status_o              = status_q;
  assign sense_reads_o         = s_reads_q;
  assign antisense_reads_o     = a_reads_q;
  assign sense_fragments_o     = s_frags_q;
  assign antisense_fragments_o = a_frags_q;
  assign metric_value_o        = metric_q;

  // --------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------
  `SFC_ASSERT(a_no_rw_collision, (ram_we && ram_re) |-> (ram_waddr != ram_raddr),
              "table read and write hit one entry")
  `SFC_ASSERT(a_b_after_a, (state_q == S_B) |-> ($past(state_q) == S_A),
              "second slot without first")
  `SFC_ASSERT(a_b_ends_item, (state_q == S_B) |=> done_o, "second slot gave no result")
  `SFC_ASSERT(a_err_fields_zero, (done_o && (status_o != ST_OK)) |->
              ((sense_reads_o == 32'd0) && (antisense_fragments_o == 32'd0) &&
               (metric_value_o == 32'd0)),
              "error result carries data")

endmodule

>>> rtl/sfc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module sfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sfc_decode.sv
// Record classifier: strand, status, table slots and metric increments.
module sfc_decode
  import sfc_pkg::*;
#(
  parameter int TARGETS = 1024
) (
  input  logic               mode_i,
  input  logic [15:0]        first_flags_i,
  input  logic signed [10:0] first_target_i,
  input  logic [15:0]        second_flags_i,
  input  logic signed [10:0] second_target_i,
  output plan_t              plan_o
);

  logic        ok1, ok2, mok, u1, u2;
  logic        r1, m1, r2, m2;
  logic [15:0] mf;
  plan_t       p;

  assign ok1 = !first_target_i[10] && ({22'd0, first_target_i[9:0]} < 32'(TARGETS));
  assign ok2 = !second_target_i[10] && ({22'd0, second_target_i[9:0]} < 32'(TARGETS));
  assign u1  = first_flags_i[FL_UNMAP];
  assign u2  = second_flags_i[FL_UNMAP];
  assign r1  = first_flags_i[FL_REV];
  assign m1  = first_flags_i[FL_MREV];
  assign r2  = second_flags_i[FL_REV];
  assign m2  = second_flags_i[FL_MREV];
  // the mapped read of a half-mapped pair
  assign mf  = u2 ? first_flags_i : second_flags_i;
  assign mok = u2 ? ok1 : ok2;

  always_comb begin
    p        = '0;
    p.status = ST_OK;
    p.a_addr = first_target_i[9:0];
    p.b_addr = second_target_i[9:0];
    if (mode_i) begin
      if (first_flags_i == 16'd0) begin
        if (!ok1) begin
          p.status = ST_NEG_TGT;
        end else begin
          p.a_valid = 1'b1;
          p.madd[M_ANTI_FRAG]  = 2'd1;
          p.madd[M_SINGLE_A]   = 2'd1;
          p.madd[M_TOTAL]      = 2'd1;
        end
      end else if (first_flags_i[FL_REV]) begin
        if (!ok1) begin
          p.status = ST_NEG_TGT;
        end else begin
          p.a_valid = 1'b1;
          p.sense   = 1'b1;
          p.madd[M_SENSE_FRAG]  = 2'd1;
          p.madd[M_SINGLE_S]    = 2'd1;
          p.madd[M_TOTAL]       = 2'd1;
        end
      end else if (first_flags_i[FL_UNMAP]) begin
        p.madd[M_UNMAPPED] = 2'd1;
        p.madd[M_TOTAL]    = 2'd1;
      end else begin
        p.status = ST_UNUSUAL;
      end
    end else if (u1 && u2) begin
      p.madd[M_UNMAPPED] = 2'd2;
      p.madd[M_TOTAL]    = 2'd2;
    end else if (!u1 && !u2) begin
      if (!(first_flags_i[FL_R1] && second_flags_i[FL_R2])) begin
        p.status = ST_ORDER;
      end else if (first_flags_i[FL_MUNMAP] || second_flags_i[FL_MUNMAP]) begin
        p.status = ST_UNLIKELY;
      end else if (!ok1 || !ok2) begin
        p.status = ST_NEG_TGT;
      end else if (!r1 && !m1 && !r2 && !m2) begin
        p.madd[M_BOTH_FWD] = 2'd2;
        p.madd[M_TOTAL]    = 2'd2;
      end else if (r1 && m1 && r2 && m2) begin
        p.madd[M_BOTH_REV] = 2'd2;
        p.madd[M_TOTAL]    = 2'd2;
      end else if ((r1 && m2) || (m1 && r2)) begin
        p.sense   = r1 && m2;
        p.a_valid = 1'b1;
        p.madd[M_TOTAL] = 2'd2;
        if (first_target_i[9:0] == second_target_i[9:0]) begin
          // both reads on one target: two reads, one fragment
          p.a_two = 1'b1;
          p.madd[p.sense ? M_SENSE_FRAG : M_ANTI_FRAG] = 2'd1;
        end else begin
          p.b_valid = 1'b1;
          p.madd[p.sense ? M_SENSE_FRAG : M_ANTI_FRAG] = 2'd2;
          p.madd[M_UNEQUAL] = 2'd1;
        end
        if (p.sense) begin
          p.madd[first_flags_i[FL_PROPER] ? M_S_R1 : M_S_R1_IMP]  = 2'd1;
          p.madd[second_flags_i[FL_PROPER] ? M_S_R2 : M_S_R2_IMP] = 2'd1;
        end else begin
          p.madd[first_flags_i[FL_PROPER] ? M_A_R1 : M_A_R1_IMP]  = 2'd1;
          p.madd[second_flags_i[FL_PROPER] ? M_A_R2 : M_A_R2_IMP] = 2'd1;
        end
      end else begin
        p.status = ST_UNLIKELY;
      end
    end else begin
      // exactly one read unmapped
      if (u2 ? !first_flags_i[FL_R1] : !second_flags_i[FL_R2]) begin
        p.status = ST_ORDER;
      end else if (!mf[FL_MUNMAP]) begin
        p.status = ST_UNUSUAL;
      end else if (!mok) begin
        p.status = ST_NEG_TGT;
      end else if (!mf[FL_R1] && !mf[FL_R2]) begin
        p.status = ST_UNUSUAL;
      end else begin
        p.a_valid = 1'b1;
        p.a_addr  = u2 ? first_target_i[9:0] : second_target_i[9:0];
        if (mf[FL_R1]) begin
          p.sense = mf[FL_REV];
          p.madd[mf[FL_REV] ? M_S_R1_MUN : M_A_R1_MUN] = 2'd1;
        end else begin
          p.sense = !mf[FL_REV];
          p.madd[mf[FL_REV] ? M_A_R2_MUN : M_S_R2_MUN] = 2'd1;
        end
        p.madd[p.sense ? M_SENSE_FRAG : M_ANTI_FRAG] = 2'd1;
        p.madd[M_UNMAPPED] = 2'd1;
        p.madd[M_TOTAL]    = 2'd2;
      end
    end
    // drop every update on error
    if (p.status != ST_OK) begin
      p.a_valid = 1'b0;
      p.b_valid = 1'b0;
      p.madd    = '0;
    end
  end

  assign plan_o = p;

endmodule

>>> rtl/sfc_metrics.sv
// Bank of saturating global metric counters with one read port.
module sfc_metrics
  import sfc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    upd_i,
  input  logic [METRICS-1:0][1:0] add_i,
  input  logic [9:0]              idx_i,
  output logic [31:0]             value_o
);

  localparam int CW = COUNT_WIDTH;

  logic [CW-1:0] cnt_q [METRICS];
  logic [CW-1:0] cnt_d [METRICS];
  logic [CW+1:0] sum   [METRICS];

  always_comb begin
    for (int m = 0; m < METRICS; m++) begin
      sum[m]   = {2'b00, cnt_q[m]} + {{CW{1'b0}}, add_i[m]};
      cnt_d[m] = (|sum[m][CW+1:CW]) ? {CW{1'b1}} : sum[m][CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < METRICS; m++) begin
        cnt_q[m] <= '0;
      end
    end else if (upd_i) begin
      for (int m = 0; m < METRICS; m++) begin
        cnt_q[m] <= cnt_d[m];
      end
    end
  end

  assign value_o = ({22'd0, idx_i} < 32'(METRICS))
                   ? 32'(64'(cnt_q[idx_i[MIDX_W-1:0]])) : 32'd0;

endmodule

>>> tb/sv/strand_fragment_counter_test.sv
// Self-checking testbench of the strand fragment counter: directed table, then random commands.
`timescale 1ns / 100ps

module strand_fragment_counter_test;
  import sfc_pkg::*;

  localparam int TARGETS = 1024;
  localparam int PREDICT = -1;            // table row checked against the shadow counters
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};
  localparam bit PAIRS = 1'b0;
  localparam bit SINGLES = 1'b1;

  // Flag masks built from the package bit positions
  localparam logic [15:0] F_PP = 16'd1 << FL_PROPER;
  localparam logic [15:0] F_UN = 16'd1 << FL_UNMAP;
  localparam logic [15:0] F_MU = 16'd1 << FL_MUNMAP;
  localparam logic [15:0] F_RV = 16'd1 << FL_REV;
  localparam logic [15:0] F_MR = 16'd1 << FL_MREV;
  localparam logic [15:0] F_R1 = 16'd1 << FL_R1;
  localparam logic [15:0] F_R2 = 16'd1 << FL_R2;
  localparam logic [15:0] PAIR_BITS = F_UN | F_MU | F_RV | F_MR | F_R1 | F_R2;

  typedef struct {
    logic [1:0]         kind;
    logic [15:0]        f1;
    logic signed [10:0] t1;
    logic [15:0]        f2;
    logic signed [10:0] t2;
    logic [9:0]         idx;
  } command_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] sr;
    logic [31:0] ar;
    logic [31:0] sf;
    logic [31:0] af;
    logic [31:0] mv;
  } response_t;

  typedef struct {
    bit                 md;
    logic [1:0]         kind;
    logic [15:0]        f1;
    logic signed [10:0] t1;
    logic [15:0]        f2;
    logic signed [10:0] t2;
    logic [9:0]         idx;
    int                 want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic [15:0]        first_flags_i;
  logic signed [10:0] first_target_i;
  logic [15:0]        second_flags_i;
  logic signed [10:0] second_target_i;
  logic [9:0]         read_index_i;
  logic               done_o;
  logic [2:0]         status_o;
  logic [31:0]        sense_reads_o;
  logic [31:0]        antisense_reads_o;
  logic [31:0]        sense_fragments_o;
  logic [31:0]        antisense_fragments_o;
  logic [31:0]        metric_value_o;

  // Shadow copy of the counters and of the mode register
  logic [31:0] sense_reads_tab [TARGETS];
  logic [31:0] anti_reads_tab [TARGETS];
  logic [31:0] sense_frag_tab [TARGETS];
  logic [31:0] anti_frag_tab [TARGETS];
  logic [31:0] metric_tab [METRICS];
  bit          mode_now;

  response_t due_responses[$];
  int        mismatches;

  // Directed rows: typed status means an all-zero payload is expected
  script_row_t script [27] = '{
    // fresh counters straight after the clearing pass
    '{PAIRS, KIND_TGT, 16'h0000, 0, 16'h0000, 0, 10'd0, ST_OK},
    '{PAIRS, KIND_TGT, 16'hFFFF, -1, 16'hFFFF, -1, 10'd1023, ST_OK},
    '{PAIRS, KIND_MET, 16'h0000, 0, 16'h0000, 0, 10'(M_TOTAL), ST_OK},
    // metric number past the last counter reads as zero
    '{PAIRS, KIND_MET, 16'h0000, 0, 16'h0000, 0, 10'd1023, ST_OK},
    // unused kind leaves everything alone
    '{PAIRS, KIND_SPARE, 16'hFFFF, 1023, 16'hFFFF, 1023, 10'd1023, ST_OK},
    '{PAIRS, KIND_REC, F_R1 | F_RV | F_PP, 0, F_R2 | F_MR | F_PP, 0, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, F_R1 | F_MR, 1023, F_R2 | F_RV, 0, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, F_R1, 5, F_R2, 5, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, F_R1 | F_RV | F_MR, 5, F_R2 | F_RV | F_MR, 6, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, 16'hFFFF, -1, 16'hFFFF, -1024, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, F_R1 | F_MU | F_RV, 3, F_UN, -1, 10'd0, PREDICT},
    // mapped second read with both read bits: read 1 wins
    '{PAIRS, KIND_REC, F_UN, -1, F_R1 | F_R2 | F_MU, 3, 10'd0, PREDICT},
    '{PAIRS, KIND_REC, F_R2, 1, F_R1, 1, 10'd0, ST_ORDER},
    '{PAIRS, KIND_REC, F_R1 | F_MU | F_RV, 1, F_R2 | F_MR, 1, 10'd0, ST_UNLIKELY},
    '{PAIRS, KIND_REC, F_R1 | F_RV, -1, F_R2 | F_MR, 0, 10'd0, ST_NEG_TGT},
    '{PAIRS, KIND_REC, F_R1 | F_RV, 2, F_R2 | F_RV, 2, 10'd0, ST_UNLIKELY},
    '{PAIRS, KIND_REC, F_R1, 3, F_UN, 3, 10'd0, ST_UNUSUAL},
    '{PAIRS, KIND_REC, F_R2 | F_MU, 3, F_UN, 3, 10'd0, ST_ORDER},
    '{PAIRS, KIND_REC, F_UN, 4, F_R2 | F_MU, -1, 10'd0, ST_NEG_TGT},
    '{PAIRS, KIND_TGT, 16'h0000, 0, 16'h0000, 0, 10'd0, PREDICT},
    '{PAIRS, KIND_TGT, 16'h0000, 0, 16'h0000, 0, 10'd1023, PREDICT},
    '{PAIRS, KIND_MET, 16'h0000, 0, 16'h0000, 0, 10'(M_UNMAPPED), PREDICT},
    // single reads: zero flag word, reverse, unmapped, anything else
    '{SINGLES, KIND_REC, 16'h0000, 1023, 16'hFFFF, -1, 10'd0, PREDICT},
    '{SINGLES, KIND_REC, F_RV, -1024, 16'h0000, 0, 10'd0, ST_NEG_TGT},
    '{SINGLES, KIND_REC, F_UN, -1, 16'h0000, 0, 10'd0, PREDICT},
    '{SINGLES, KIND_REC, F_R1, 7, 16'h0000, 0, 10'd0, ST_UNUSUAL},
    '{SINGLES, KIND_MET, 16'h0000, 0, 16'h0000, 0, 10'(M_SINGLE_A), PREDICT}
  };

  strand_fragment_counter #(
    .TARGETS    (TARGETS),
    .COUNT_WIDTH(32)
  ) DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .start                (start),
    .busy                 (busy),
    .kind_i               (kind_i),
    .first_flags_i        (first_flags_i),
    .first_target_i       (first_target_i),
    .second_flags_i       (second_flags_i),
    .second_target_i      (second_target_i),
    .read_index_i         (read_index_i),
    .done_o               (done_o),
    .status_o             (status_o),
    .sense_reads_o        (sense_reads_o),
    .antisense_reads_o    (antisense_reads_o),
    .sense_fragments_o    (sense_fragments_o),
    .antisense_fragments_o(antisense_fragments_o),
    .metric_value_o       (metric_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow counter arithmetic
  // ---------------------------------------------------------------------------

  // Add with saturation at the all-ones value
  function automatic logic [31:0] sat_add(logic [31:0] v, int unsigned n);
    logic [32:0] sum;
    sum = {1'b0, v} + 33'(n);
    return sum[32] ? '1 : sum[31:0];
  endfunction

  function automatic void bump(int m, int unsigned n);
    metric_tab[m] = sat_add(metric_tab[m], n);
  endfunction

  // One fragment and nreads reads to a target, plus the strand fragment metric
  function automatic void credit(logic [9:0] t, bit sense, int unsigned nreads);
    if (sense) begin
      sense_frag_tab[t] = sat_add(sense_frag_tab[t], 1);
      sense_reads_tab[t] = sat_add(sense_reads_tab[t], nreads);
      bump(M_SENSE_FRAG, 1);
    end else begin
      anti_frag_tab[t] = sat_add(anti_frag_tab[t], 1);
      anti_reads_tab[t] = sat_add(anti_reads_tab[t], nreads);
      bump(M_ANTI_FRAG, 1);
    end
  endfunction

  // Mapped read whose mate is unmapped
  function automatic logic [2:0] count_lone(logic [15:0] f, logic signed [10:0] t);
    if (!f[FL_MUNMAP])
      return ST_UNUSUAL;
    if (t[10])
      return ST_NEG_TGT;
    if (f[FL_R1]) begin
      credit(t[9:0], f[FL_REV], 1);
      bump(f[FL_REV] ? M_S_R1_MUN : M_A_R1_MUN, 1);
    end else if (f[FL_R2]) begin
      credit(t[9:0], !f[FL_REV], 1);
      bump(f[FL_REV] ? M_A_R2_MUN : M_S_R2_MUN, 1);
    end else begin
      return ST_UNUSUAL;
    end
    bump(M_UNMAPPED, 1);
    return ST_OK;
  endfunction

  function automatic logic [2:0] count_mapped(logic [15:0] f1, logic signed [10:0] t1,
                                              logic [15:0] f2, logic signed [10:0] t2);
    bit sense;
    if (!(f1[FL_R1] && f2[FL_R2]))
      return ST_ORDER;
    if (f1[FL_MUNMAP] || f2[FL_MUNMAP])
      return ST_UNLIKELY;
    if (t1[10] || t2[10])
      return ST_NEG_TGT;
    if (!f1[FL_REV] && !f1[FL_MREV] && !f2[FL_REV] && !f2[FL_MREV]) begin
      bump(M_BOTH_FWD, 2);
      return ST_OK;
    end
    if (f1[FL_REV] && f1[FL_MREV] && f2[FL_REV] && f2[FL_MREV]) begin
      bump(M_BOTH_REV, 2);
      return ST_OK;
    end
    if (f1[FL_REV] && f2[FL_MREV])
      sense = 1'b1;
    else if (f1[FL_MREV] && f2[FL_REV])
      sense = 1'b0;
    else
      return ST_UNLIKELY;
    if (t1 == t2) begin
      credit(t1[9:0], sense, 2);
    end else begin
      credit(t1[9:0], sense, 1);
      credit(t2[9:0], sense, 1);
      bump(M_UNEQUAL, 1);
    end
    // proper-pair bit of each read picks its proper or improper metric
    if (sense) begin
      bump(f1[FL_PROPER] ? M_S_R1 : M_S_R1_IMP, 1);
      bump(f2[FL_PROPER] ? M_S_R2 : M_S_R2_IMP, 1);
    end else begin
      bump(f1[FL_PROPER] ? M_A_R1 : M_A_R1_IMP, 1);
      bump(f2[FL_PROPER] ? M_A_R2 : M_A_R2_IMP, 1);
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] count_pair(logic [15:0] f1, logic signed [10:0] t1,
                                            logic [15:0] f2, logic signed [10:0] t2);
    logic [2:0] st;
    if (f1[FL_UNMAP] && f2[FL_UNMAP]) begin
      bump(M_UNMAPPED, 2);
      st = ST_OK;
    end else if (!f1[FL_UNMAP] && !f2[FL_UNMAP]) begin
      st = count_mapped(f1, t1, f2, t2);
    end else if (f2[FL_UNMAP]) begin
      st = f1[FL_R1] ? count_lone(f1, t1) : ST_ORDER;
    end else begin
      st = f2[FL_R2] ? count_lone(f2, t2) : ST_ORDER;
    end
    if (st == ST_OK)
      bump(M_TOTAL, 2);
    return st;
  endfunction

  function automatic logic [2:0] count_single(logic [15:0] f, logic signed [10:0] t);
    if (f == 16'h0000) begin
      if (t[10])
        return ST_NEG_TGT;
      credit(t[9:0], 1'b0, 1);
      bump(M_SINGLE_A, 1);
    end else if (f[FL_REV]) begin
      if (t[10])
        return ST_NEG_TGT;
      credit(t[9:0], 1'b1, 1);
      bump(M_SINGLE_S, 1);
    end else if (f[FL_UNMAP]) begin
      bump(M_UNMAPPED, 1);
    end else begin
      return ST_UNUSUAL;
    end
    bump(M_TOTAL, 1);
    return ST_OK;
  endfunction

  // Apply one command to the shadow counters and return the response it earns
  function automatic response_t tally_command(command_t c);
    response_t r;
    r = '{status: ST_OK, sr: '0, ar: '0, sf: '0, af: '0, mv: '0};
    case (c.kind)
      KIND_REC: r.status = mode_now ? count_single(c.f1, c.t1)
                                    : count_pair(c.f1, c.t1, c.f2, c.t2);
      // a 10-bit index never reaches past the table at this size
      KIND_TGT: begin
        r.sr = sense_reads_tab[c.idx];
        r.ar = anti_reads_tab[c.idx];
        r.sf = sense_frag_tab[c.idx];
        r.af = anti_frag_tab[c.idx];
      end
      KIND_MET: if (c.idx < METRICS) r.mv = metric_tab[c.idx];
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random commands
  // ---------------------------------------------------------------------------

  // Mostly a small hot set, so that read-outs see counts build up
  function automatic logic signed [10:0] draw_target();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      v = $urandom_range(0, 15);
    else if (pick < 70)
      v = 1023 - $urandom_range(0, 1);
    else if (pick < 95)
      v = $urandom_range(0, 1023);
    else
      v = -int'($urandom_range(1, 1024));
    return v[10:0];
  endfunction

  function automatic command_t draw_command();
    command_t c;
    int shape;
    c.kind = KIND_REC;
    c.f1 = 16'($urandom_range(0, 65535));
    c.f2 = 16'($urandom_range(0, 65535));
    c.t1 = draw_target();
    c.t2 = ($urandom_range(0, 9) < 4) ? c.t1 : draw_target();
    c.idx = 10'($urandom_range(0, 1023));
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      c.kind = KIND_TGT;
      if ($urandom_range(0, 9) < 7)
        c.idx = 10'($urandom_range(0, 15));
      return c;
    end
    if (shape < 28) begin
      c.kind = KIND_MET;
      if ($urandom_range(0, 9) < 9)
        c.idx = 10'($urandom_range(0, METRICS - 1));
      return c;
    end
    shape = $urandom_range(0, 99);
    if (mode_now) begin
      if (shape < 30) begin
        c.f1 = 16'h0000;
      end else if (shape < 65) begin
        c.f1 |= F_RV;
      end else if (shape < 85) begin
        c.f1 &= ~F_RV;
        c.f1 |= F_UN;
      end
      return c;
    end
    // leave a tenth as raw noise, shape the rest into plausible pairs
    if (shape >= 90)
      return c;
    c.f1 &= ~PAIR_BITS;
    c.f2 &= ~PAIR_BITS;
    if (shape < 50) begin
      c.f1 |= F_R1;
      c.f2 |= F_R2;
      if ($urandom_range(0, 1)) begin
        c.f1 |= F_RV;
        c.f2 |= F_MR;
        if ($urandom_range(0, 3) == 0) c.f1 |= F_MR;
        if ($urandom_range(0, 3) == 0) c.f2 |= F_RV;
      end else begin
        c.f1 |= F_MR;
        c.f2 |= F_RV;
        if ($urandom_range(0, 3) == 0) c.f1 |= F_RV;
        if ($urandom_range(0, 3) == 0) c.f2 |= F_MR;
      end
    end else if (shape < 60) begin
      c.f1 |= F_R1;
      c.f2 |= F_R2;
      if ($urandom_range(0, 1)) begin
        c.f1 |= F_RV | F_MR;
        c.f2 |= F_RV | F_MR;
      end
    end else if (shape < 80) begin
      if ($urandom_range(0, 1)) begin
        c.f2 |= F_UN;
        c.f1 |= F_MU;
        if ($urandom_range(0, 9) != 0) c.f1 |= F_R1;
        if ($urandom_range(0, 4) == 0) c.f1 |= F_R2;
        if ($urandom_range(0, 1)) c.f1 |= F_RV;
      end else begin
        c.f1 |= F_UN;
        c.f2 |= F_MU;
        if ($urandom_range(0, 9) != 0) c.f2 |= F_R2;
        if ($urandom_range(0, 4) == 0) c.f2 |= F_R1;
        if ($urandom_range(0, 1)) c.f2 |= F_RV;
      end
    end else begin
      c.f1 |= F_UN;
      c.f2 |= F_UN;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus activity
  // ---------------------------------------------------------------------------

  // Hold start low for gap cycles, then offer the command until it is taken.
  // Work out the response at the accepting edge, in transfer order.
  task automatic issue(command_t c, int want, int gap);
    response_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i          <= c.kind;
    first_flags_i   <= c.f1;
    first_target_i  <= c.t1;
    second_flags_i  <= c.f2;
    second_target_i <= c.t2;
    read_index_i    <= c.idx;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = tally_command(c);
    if (want != PREDICT)
      r = '{status: 3'(want), sr: '0, ar: '0, sf: '0, af: '0, mv: '0};
    due_responses.push_back(r);
  endtask

  // Drop start and wait for every outstanding response
  task automatic settle();
    start <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
  endtask

  // Write the mode register through a setup and an access cycle, then read it back
  task automatic set_mode(bit m);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    mode_now = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= '0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'd0, m}) begin
      $error("mode: expected %0d, actual %0d", m, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response checking: every strobe is a transfer the receiver must take
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_responses
    response_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (due_responses.size() == 0) begin
        $error("status: expected no transfer, actual %0d", status_o);
        mismatches++;
      end else begin
        want = due_responses.pop_front();
        check_field("status", want.status, status_o);
        check_field("sense_reads", want.sr, sense_reads_o);
        check_field("antisense_reads", want.ar, antisense_reads_o);
        check_field("sense_fragments", want.sf, sense_fragments_o);
        check_field("antisense_fragments", want.af, antisense_fragments_o);
        check_field("metric_value", want.mv, metric_value_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    command_t c;
    bit       phase_modes [4];
    bit       burst;
    int       n;
    phase_modes = '{PAIRS, SINGLES, PAIRS, SINGLES};
    mismatches = 0;
    mode_now = PAIRS;
    for (int i = 0; i < TARGETS; i++) begin
      sense_reads_tab[i] = '0;
      anti_reads_tab[i]  = '0;
      sense_frag_tab[i]  = '0;
      anti_frag_tab[i]   = '0;
    end
    for (int i = 0; i < METRICS; i++)
      metric_tab[i] = '0;

    // Initialise every input before the first edge
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    start           <= 1'b0;
    kind_i          <= KIND_REC;
    first_flags_i   <= '0;
    first_target_i  <= '0;
    second_flags_i  <= '0;
    second_target_i <= '0;
    read_index_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the clearing pass over the table has finished
    do @(posedge clk_i); while (busy !== 1'b0);
    set_mode(PAIRS);

    // Directed table; switch the mode only once the block has drained
    foreach (script[i]) begin
      if (script[i].md != mode_now) begin
        settle();
        set_mode(script[i].md);
      end
      c = '{kind: script[i].kind, f1: script[i].f1, t1: script[i].t1,
            f2: script[i].f2, t2: script[i].t2, idx: script[i].idx};
      issue(c, script[i].want, $urandom_range(0, 3));
    end

    // Random phases, alternating between the two modes
    burst = 1'b0;
    foreach (phase_modes[p]) begin
      settle();
      set_mode(phase_modes[p]);
      for (n = 0; n < 475; n++) begin
        // redraw now and then whether this stretch runs back to back
        if (n % 40 == 0)
          burst = ($urandom_range(0, 2) == 0);
        // occasionally pause the sender until the block is empty
        if ($urandom_range(0, 149) == 0)
          settle();
        issue(draw_command(), PREDICT, burst ? 0 : $urandom_range(0, 12));
      end
    end

    settle();
    // allow for a stray strobe after the last transfer
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && due_responses.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> strand_fragment_counter.f
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_ram.sv
rtl/sfc_decode.sv
rtl/sfc_metrics.sv
rtl/strand_fragment_counter.sv
tb/sv/strand_fragment_counter_test.sv
